FILE: rtl/core/pdfm_pkg.sv
// pdfm_pkg: shared types and constants for the PWM duty and frequency meter.
// No dependencies; used by pdfm_front, pdfm_queue, pdfm_back and the top level.
package pdfm_pkg;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_ADDR_BITS = 2;

   localparam int              CLOCK_BITS  = 24;
   localparam logic [23:0]     CLOCK_RESET = 24'd1000000;

   localparam int              OUT_BITS    = 16;
   localparam int              DUTY_BITS   = 7;
   localparam logic [6:0]      DUTY_FULL   = 7'd100;
   localparam logic [15:0]     OUT_SAT     = 16'hFFFF;

   localparam int              DUTY_STEPS  = 7;
   localparam int              FREQ_STEPS  = 16;
   localparam int              STEP_BITS   = 4;

   typedef enum logic [2:0] {
      PH_RISE1 = 3'b001,
      PH_FALL  = 3'b010,
      PH_RISE2 = 3'b100
   } phase_type;

   typedef enum logic [3:0] {
      BK_IDLE = 4'b0001,
      BK_DUTY = 4'b0010,
      BK_FREQ = 4'b0100,
      BK_DONE = 4'b1000
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/core/pdfm_front.sv
// pdfm_front: tick counter, edge detector and capture sequencer.
// Pushes raw period and high time words to the queue; uses pdfm_pkg.
module pdfm_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  pin_level,
   output logic                  q_push,
   output logic [COUNT_BITS-1:0] q_period,
   output logic [COUNT_BITS-1:0] q_high
);
   import pdfm_pkg::*;

   logic [COUNT_BITS-1:0] tick_ff, tick_in;
   logic [COUNT_BITS-1:0] rise_ff, rise_in;
   logic [COUNT_BITS-1:0] fall_ff, fall_in;
   logic                  prev_ff, prev_in;
   phase_type             phase_ff, phase_in;
   logic                  rise, fall, done;

   assign rise = pin_level & ~prev_ff;
   assign fall = ~pin_level & prev_ff;

   always_comb begin
      tick_in  = tick_ff;
      rise_in  = rise_ff;
      fall_in  = fall_ff;
      prev_in  = prev_ff;
      phase_in = phase_ff;
      done     = 1'b0;
      if (accept) begin
         tick_in = tick_ff + COUNT_BITS'(1);
         prev_in = pin_level;
         unique case (phase_ff)
            PH_FALL: begin
               if (fall) begin
                  fall_in  = tick_ff;
                  phase_in = PH_RISE2;
               end
            end
            PH_RISE2: begin
               if (rise) begin
                  done     = 1'b1;
                  phase_in = PH_RISE1;
               end
            end
            default: begin
               if (rise) begin
                  rise_in  = tick_ff;
                  phase_in = PH_FALL;
               end else begin
                  phase_in = PH_RISE1;
               end
            end
         endcase
      end
   end

   assign q_push   = done;
   assign q_period = tick_ff - rise_ff;
   assign q_high   = fall_ff - rise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         rise_ff  <= '0;
         fall_ff  <= '0;
         prev_ff  <= 1'b0;
         phase_ff <= PH_RISE1;
      end else begin
         tick_ff  <= tick_in;
         rise_ff  <= rise_in;
         fall_ff  <= fall_in;
         prev_ff  <= prev_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: rtl/core/pdfm_queue.sv
// pdfm_queue: short register queue between capture front and divider back.
// Uses pdfm_pkg for depth and status struct.
module pdfm_queue #(
   parameter int WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop_req,
   output logic [WIDTH-1:0]            pop_data,
   output pdfm_pkg::queue_status_type  status
);
   import pdfm_pkg::*;

   logic [WIDTH-1:0]             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_BITS-1:0]   wr_ff, wr_in;
   logic [QUEUE_ADDR_BITS-1:0]   rd_ff, rd_in;
   logic [QUEUE_ADDR_BITS:0]     cnt_ff, cnt_in;
   logic                         do_push, do_pop;

   assign status.full  = (cnt_ff == (QUEUE_ADDR_BITS+1)'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop_req & ~status.empty;
   assign pop_data     = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + QUEUE_ADDR_BITS'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + QUEUE_ADDR_BITS'(1) : rd_ff;
      cnt_in = cnt_ff + (QUEUE_ADDR_BITS+1)'(do_push) - (QUEUE_ADDR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/pdfm_back.sv
// pdfm_back: shift-subtract divider for duty and frequency, clock register
// and result output register. Uses pdfm_pkg.
module pdfm_back #(
   parameter int COUNT_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [23:0]                 csr_write_data,
   input  pdfm_pkg::queue_status_type  q_status,
   input  logic [2*COUNT_BITS-1:0]     q_data,
   output logic                        q_pop,
   output logic                        empty,
   input  logic                        pop,
   output logic [15:0]                 rsp_period_ticks,
   output logic [15:0]                 rsp_high_ticks,
   output logic [6:0]                  rsp_duty_percent,
   output logic [15:0]                 rsp_frequency_hz,
   output logic                        rsp_period_zero
);
   import pdfm_pkg::*;

   localparam int W = COUNT_BITS + 16;

   logic [CLOCK_BITS-1:0] clk_hz_ff;
   back_state_type        state_ff, state_in;
   logic [COUNT_BITS-1:0] per_ff, per_in, high_ff, high_in;
   logic [W-1:0]          rem_ff, rem_in, sdiv_ff, sdiv_in;
   logic [15:0]           quo_ff, quo_in, quo_next;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  dsat_ff, dsat_in, fsat_ff, fsat_in;
   logic [6:0]            duty_ff, duty_in;
   logic [15:0]           freq_ff, freq_in;
   logic                  ge, load_out, zero;
   logic [COUNT_BITS-1:0] in_per, in_high;

   logic                  o_valid_ff, o_valid_in;
   logic [15:0]           o_period_ff, o_high_ff, o_freq_ff;
   logic [6:0]            o_duty_ff;
   logic                  o_zero_ff;

   assign in_per   = q_data[2*COUNT_BITS-1:COUNT_BITS];
   assign in_high  = q_data[COUNT_BITS-1:0];
   assign ge       = (rem_ff >= sdiv_ff);
   assign quo_next = {quo_ff[14:0], ge};
   assign zero     = (per_ff == '0);

   always_comb begin
      state_in = state_ff;
      per_in   = per_ff;
      high_in  = high_ff;
      rem_in   = rem_ff;
      sdiv_in  = sdiv_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      dsat_in  = dsat_ff;
      fsat_in  = fsat_ff;
      duty_in  = duty_ff;
      freq_in  = freq_ff;
      q_pop    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               per_in   = in_per;
               high_in  = in_high;
               rem_in   = W'(in_high) * W'(DUTY_FULL);
               sdiv_in  = W'(in_per) << (DUTY_STEPS - 1);
               dsat_in  = (in_high >= in_per);
               quo_in   = '0;
               step_in  = STEP_BITS'(DUTY_STEPS - 1);
               state_in = BK_DUTY;
            end
         end
         BK_DUTY: begin
            rem_in  = ge ? rem_ff - sdiv_ff : rem_ff;
            sdiv_in = sdiv_ff >> 1;
            quo_in  = quo_next;
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               duty_in  = dsat_ff ? DUTY_FULL : quo_next[6:0];
               rem_in   = W'(clk_hz_ff);
               sdiv_in  = W'(per_ff) << (FREQ_STEPS - 1);
               fsat_in  = (W'(clk_hz_ff) >= (W'(per_ff) << FREQ_STEPS));
               quo_in   = '0;
               step_in  = STEP_BITS'(FREQ_STEPS - 1);
               state_in = BK_FREQ;
            end
         end
         BK_FREQ: begin
            rem_in  = ge ? rem_ff - sdiv_ff : rem_ff;
            sdiv_in = sdiv_ff >> 1;
            quo_in  = quo_next;
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               freq_in  = fsat_ff ? OUT_SAT : quo_next;
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!o_valid_ff || pop) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      if (pop && o_valid_ff) begin
         o_valid_in = 1'b0;
      end
      if (load_out) begin
         o_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      per_ff  <= per_in;
      high_ff <= high_in;
      rem_ff  <= rem_in;
      sdiv_ff <= sdiv_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      dsat_ff <= dsat_in;
      fsat_ff <= fsat_in;
      duty_ff <= duty_in;
      freq_ff <= freq_in;
      if (load_out) begin
         o_period_ff <= (W'(per_ff) > W'(OUT_SAT)) ? OUT_SAT : 16'(per_ff);
         o_high_ff   <= (W'(high_ff) > W'(OUT_SAT)) ? OUT_SAT : 16'(high_ff);
         o_duty_ff   <= zero ? '0 : duty_ff;
         o_freq_ff   <= zero ? '0 : freq_ff;
         o_zero_ff   <= zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         o_valid_ff <= 1'b0;
         clk_hz_ff  <= CLOCK_RESET;
      end else begin
         state_ff   <= state_in;
         o_valid_ff <= o_valid_in;
         if (csr_write_enable) begin
            clk_hz_ff <= csr_write_data;
         end
      end
   end

   assign empty            = ~o_valid_ff;
   assign rsp_period_ticks = o_period_ff;
   assign rsp_high_ticks   = o_high_ff;
   assign rsp_duty_percent = o_duty_ff;
   assign rsp_frequency_hz = o_freq_ff;
   assign rsp_period_zero  = o_zero_ff;

endmodule

FILE: rtl/core/pwm_duty_and_frequency_meter_unit.sv
// PWM duty and frequency meter, top level: front, queue and divider back.
// Depends on pdfm_pkg, pdfm_front, pdfm_queue and pdfm_back.
//
// One timer tick with the sampled pin level is taken every clock cycle in which
// push is high and full is low. Each rise-fall-rise sequence yields one word:
// period, high time, duty (0..100) and timer_clock_hz/period saturated to
// 65535. Each measured period then passes through the shared shift-subtract
// divider (a load, 7 duty steps, 16 frequency steps and an output step that
// waits while the output register holds an unpopped word). A four-word queue
// sits between them, so full rises when short periods outpace the divider,
// or when result words are not popped and the queue backs up behind the
// output register. csr_write_data sets timer_clock_hz.
module pwm_duty_and_frequency_meter_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_pin_level,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_period_ticks,
   output logic [15:0] rsp_high_ticks,
   output logic [6:0]  rsp_duty_percent,
   output logic [15:0] rsp_frequency_hz,
   output logic        rsp_period_zero,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data
);
   import pdfm_pkg::*;

   queue_status_type        q_status;
   logic                    q_push, q_pop;
   logic [COUNT_BITS-1:0]   q_period, q_high;
   logic [2*COUNT_BITS-1:0] q_data;

   assign full = q_status.full;

   pdfm_front #(.COUNT_BITS(COUNT_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (push & ~q_status.full),
      .pin_level (req_pin_level),
      .q_push    (q_push),
      .q_period  (q_period),
      .q_high    (q_high)
   );

   pdfm_queue #(.WIDTH(2*COUNT_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({q_period, q_high}),
      .pop_req   (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   pdfm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .empty            (empty),
      .pop              (pop),
      .rsp_period_ticks (rsp_period_ticks),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_frequency_hz (rsp_frequency_hz),
      .rsp_period_zero  (rsp_period_zero)
   );

endmodule

FILE: rtl/core/pdfm_checker.sv
// pdfm_checker: port-level assertions for the PWM meter, bound to the top.
// Depends only on the top-level ports.
module pdfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [15:0] rsp_period_ticks,
   input logic [15:0] rsp_high_ticks,
   input logic [6:0]  rsp_duty_percent,
   input logic [15:0] rsp_frequency_hz,
   input logic        rsp_period_zero
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_period_ticks) &&
      $stable(rsp_high_ticks) && $stable(rsp_duty_percent) &&
      $stable(rsp_frequency_hz) && $stable(rsp_period_zero)))
      else $error("stalled result word changed");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_duty_percent <= 7'd100))
      else $error("duty above full scale");

   a_zero_forced: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_period_zero) |->
      (rsp_duty_percent == 7'd0 && rsp_frequency_hz == 16'd0 &&
       rsp_period_ticks == 16'd0))
      else $error("zero period word carries nonzero quotients");

endmodule

bind pwm_duty_and_frequency_meter_unit pdfm_checker u_pdfm_checker (.*);

FILE: dv/pdfm_meter_checker.sv
// Checker for the PWM duty and frequency meter: predicts each measurement word
// from the accepted ticks and compares it with the words popped from the block.
// Depends on pdfm_pkg only.
module pdfm_meter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic        req_pin_level,
   input  logic        empty,
   input  logic        pop,
   input  logic [15:0] rsp_period_ticks,
   input  logic [15:0] rsp_high_ticks,
   input  logic [6:0]  rsp_duty_percent,
   input  logic [15:0] rsp_frequency_hz,
   input  logic        rsp_period_zero,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data,
   output int          fail_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import pdfm_pkg::*;

   typedef struct packed {
      logic [15:0] period_ticks;
      logic [15:0] high_ticks;
      logic [6:0]  duty_percent;
      logic [15:0] frequency_hz;
      logic        period_zero;
   } meter_word_type;

   meter_word_type expected_words[$];
   logic [23:0] timer_hz;
   logic [15:0] tick_count;
   logic [15:0] first_rise_time;
   logic [15:0] fall_time;
   logic        prev_level;
   phase_type   phase;
   int          failures;

   function automatic meter_word_type measure_period(input logic [15:0] now);
      meter_word_type w;
      logic [15:0] period;
      logic [15:0] high;
      logic [31:0] duty;
      logic [23:0] freq;
      period = now - first_rise_time;
      high   = fall_time - first_rise_time;
      w = '0;
      w.period_ticks = period;
      w.high_ticks   = high;
      if (period == 16'd0) begin
         w.period_zero = 1'b1;
      end else begin
         duty = (32'(high) * 32'd100) / 32'(period);
         w.duty_percent = (duty > 32'(DUTY_FULL)) ? DUTY_FULL : duty[6:0];
         freq = timer_hz / {8'd0, period};
         w.frequency_hz = (freq > {8'd0, OUT_SAT}) ? OUT_SAT : freq[15:0];
      end
      return w;
   endfunction

   task automatic take_tick(input logic level);
      logic rise;
      logic fall;
      rise = level && !prev_level;
      fall = !level && prev_level;
      case (phase)
         PH_FALL: begin
            if (fall) begin
               fall_time = tick_count;
               phase = PH_RISE2;
            end
         end
         PH_RISE2: begin
            if (rise) begin
               expected_words.push_back(measure_period(tick_count));
               phase = PH_RISE1;
            end
         end
         default: begin
            if (rise) begin
               first_rise_time = tick_count;
               phase = PH_FALL;
            end else begin
               phase = PH_RISE1;
            end
         end
      endcase
      tick_count = tick_count + 16'd1;
      prev_level = level;
   endtask

   task automatic note_failure(input string what, input meter_word_type want,
                               input meter_word_type got);
      failures++;
      if (failures <= 10) begin
         $display("[%0t] %s: want p=%0d h=%0d d=%0d f=%0d z=%0d",
                  $time, what, want.period_ticks, want.high_ticks,
                  want.duty_percent, want.frequency_hz, want.period_zero);
         $display("[%0t] %s: got  p=%0d h=%0d d=%0d f=%0d z=%0d",
                  $time, what, got.period_ticks, got.high_ticks,
                  got.duty_percent, got.frequency_hz, got.period_zero);
      end
   endtask

   task automatic check_word(input meter_word_type got);
      meter_word_type want;
      if (expected_words.size() == 0) begin
         note_failure("unexpected word", '0, got);
      end else begin
         want = expected_words.pop_front();
         if (got.period_ticks !== want.period_ticks ||
             got.high_ticks !== want.high_ticks ||
             got.duty_percent !== want.duty_percent ||
             got.frequency_hz !== want.frequency_hz ||
             got.period_zero !== want.period_zero)
            note_failure("word mismatch", want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timer_hz        = CLOCK_RESET;
         tick_count      = '0;
         first_rise_time = '0;
         fall_time       = '0;
         prev_level      = 1'b0;
         phase           = PH_RISE1;
         failures        = 0;
         expected_words.delete();
      end else begin
         if (csr_write_enable)
            timer_hz = csr_write_data;
         // pop is checked first so a word can never match a tick of the same edge
         if (pop && !empty)
            check_word({rsp_period_ticks, rsp_high_ticks, rsp_duty_percent,
                        rsp_frequency_hz, rsp_period_zero});
         if (push && !full)
            take_tick(req_pin_level);
      end
      fail_count    <= failures;
      pending_words <= expected_words.size();
   end

endmodule

FILE: dv/pwm_duty_and_frequency_meter_unit_tb.sv
// Testbench top for pwm_duty_and_frequency_meter_unit: drives pin-level ticks,
// timer clock settings and result pops, and gives the verdict.
// Depends on pdfm_pkg, the block and pdfm_meter_checker.
module pwm_duty_and_frequency_meter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pdfm_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic        req_pin_level;
   logic        empty;
   logic        pop;
   logic [15:0] rsp_period_ticks;
   logic [15:0] rsp_high_ticks;
   logic [6:0]  rsp_duty_percent;
   logic [15:0] rsp_frequency_hz;
   logic        rsp_period_zero;
   logic        csr_write_enable;
   logic [23:0] csr_write_data;

   int fail_count;
   int pending_words;
   int ticks_sent;
   int gap_odds;
   int stall_odds;
   bit hold_request;

   pwm_duty_and_frequency_meter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_pin_level    (req_pin_level),
      .empty            (empty),
      .pop              (pop),
      .rsp_period_ticks (rsp_period_ticks),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_frequency_hz (rsp_frequency_hz),
      .rsp_period_zero  (rsp_period_zero),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   pdfm_meter_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_pin_level    (req_pin_level),
      .empty            (empty),
      .pop              (pop),
      .rsp_period_ticks (rsp_period_ticks),
      .rsp_high_ticks   (rsp_high_ticks),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_frequency_hz (rsp_frequency_hz),
      .rsp_period_zero  (rsp_period_zero),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_words    (pending_words)
   );

   always #5 clock = ~clock;

   initial begin
      #(200_000_000);
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_tick(input logic level);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      push <= 1'b1;
      req_pin_level <= level;
      @(posedge clock);
      while (full) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic send_wave(input int high_len, input int low_len);
      repeat (high_len) send_tick(1'b1);
      repeat (low_len) send_tick(1'b0);
   endtask

   task automatic random_waves(input int n_ticks);
      int start;
      start = ticks_sent;
      while (ticks_sent - start < n_ticks) begin
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
            1: send_wave($urandom_range(1, 300), $urandom_range(1, 300));
            default: send_wave($urandom_range(1, 12), $urandom_range(1, 12));
         endcase
      end
   endtask

   // timer clock changes only with the block drained
   task automatic set_timer_hz(input logic [23:0] hz);
      push <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= hz;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int hold;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            pop <= 1'b0;
            for (hold = 0; hold < 600; hold++) @(posedge clock);
         end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      int waited;
      reset            = 1'b1;
      push             = 1'b0;
      pop              = 1'b0;
      req_pin_level    = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      ticks_sent       = 0;
      gap_odds         = 0;
      stall_odds       = 4;
      hold_request     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // pin high on the first tick, then short and 16-tick periods
      send_wave(2, 1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_wave(4, 12);
      send_tick(1'b1);

      // counter wraps: zero period, high time above period, longest period
      gap_odds = 200;
      send_tick(1'b0);
      send_wave(3, 65533);
      send_tick(1'b1);
      send_tick(1'b0);
      send_wave(40000, 30000);
      send_tick(1'b1);
      send_tick(1'b0);
      send_wave(1, 65534);
      send_tick(1'b1);

      gap_odds = 8;
      random_waves(300);

      // long receiver hold-off while short periods keep coming
      gap_odds = 0;
      hold_request = 1'b1;
      repeat (150) send_wave(1, 1);

      gap_odds = 6;
      set_timer_hz(24'd16000000);
      random_waves(300);
      set_timer_hz(24'd1);
      random_waves(250);
      stall_odds = 0;
      set_timer_hz(24'd0);
      random_waves(250);
      stall_odds = 3;
      set_timer_hz(24'hFFFFFF);
      random_waves(300);
      set_timer_hz(24'($urandom_range(1, 16000000)));
      gap_odds = 3;
      random_waves(300);

      gap_odds   = 0;
      stall_odds = 0;
      set_timer_hz(24'($urandom_range(1000, 2000000)));
      random_waves(300);

      push <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_words != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_words != 0) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         repeat (60) @(posedge clock);
         if (fail_count == 0 && pending_words == 0)
            $display("TB_OK");
         else
            $display("TB_ERROR");
         $finish;
      end
   end

endmodule
